// ----- rtl/plbt_pkg.sv -----
// Package for the piecewise linear breakpoint table.
// Holds sizes, coordinate types, command and status codes, register indexes.
// Used by the interfaces, the divider and the top level.
`default_nettype none
package plbt_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int DIV_W       = COORD_WIDTH + 1;

  localparam int CMD_W    = 3;
  localparam int PIDX_W   = 4;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [DIV_W-1:0] divw_t;

  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP_X    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FEW      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  localparam coord_t RST_X_MIN = COORD_WIDTH'(-16384);
  localparam coord_t RST_X_MAX = COORD_WIDTH'(16384);
  localparam coord_t RST_Y_MIN = COORD_WIDTH'(0);
  localparam coord_t RST_Y_MAX = COORD_WIDTH'(255);
  localparam coord_t RST_MID   = COORD_WIDTH'(127);

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [2*DIV_W-1:0]   dividend;
    divw_t                divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    divw_t  quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/plbt_if.sv -----
// Valid/ready channel interfaces of the breakpoint table: command items,
// result items and configuration writes. Depends on plbt_pkg.
`default_nettype none
interface plbt_in_if;
  logic                          valid;
  logic                          ready;
  logic [plbt_pkg::CMD_W-1:0]    cmd;
  logic [plbt_pkg::PIDX_W-1:0]   point_index;
  plbt_pkg::coord_t              x_coord;
  plbt_pkg::coord_t              y_coord;
  modport source (output valid, cmd, point_index, x_coord, y_coord, input ready);
  modport sink   (input valid, cmd, point_index, x_coord, y_coord, output ready);
endinterface

interface plbt_out_if;
  logic                            valid;
  logic                            ready;
  plbt_pkg::coord_t                value;
  logic [plbt_pkg::STATUS_W-1:0]   status;
  logic [plbt_pkg::CNT_W-1:0]      point_count;
  modport source (output valid, value, status, point_count, input ready);
  modport sink   (input valid, value, status, point_count, output ready);
endinterface

interface plbt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [plbt_pkg::CFG_IDX_W-1:0]   index;
  plbt_pkg::coord_t                 data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/plbt_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// The quotient must fit DIV_W bits. Depends on plbt_pkg.
`default_nettype none
module plbt_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire plbt_pkg::div_req_t req_i,
  output plbt_pkg::div_rsp_t      rsp_o
);
  import plbt_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  divw_t              rem_q, rem_d;
  divw_t              num_q, num_d;
  divw_t              den_q, den_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     diff;

  // One shift-subtract step
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[DIV_W-1]};
    diff   = trial - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = req_i.dividend[2*DIV_W-1:DIV_W];
      num_d  = req_i.dividend[DIV_W-1:0];
      den_d  = req_i.divisor;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DIV_W]) begin
        rem_d = diff[DIV_W-1:0];
        num_d = {num_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_W-1:0];
        num_d = {num_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule
`default_nettype wire

// ----- rtl/piecewise_linear_breakpoint_table.sv -----
// Piecewise linear breakpoint table. Holds up to 16 points sorted by x and
// runs one command item at a time under a sequencer; in_i.ready is low while
// an item is at work. Init and remove finish in the dispatch state, add scans
// the table and then inserts, set does a scan for a clash, then a scan for the
// insert position, and evaluate scans the table one entry a cycle and, unless
// it clamps at an end, runs one 17x17 multiply and the divider. A finished
// result sits in an output register so the next item can enter; a result
// still held there stalls the next one at its end.
`default_nettype none
module piecewise_linear_breakpoint_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plbt_in_if.sink   in_i,
  plbt_out_if.source out_o,
  plbt_cfg_if.sink  cfg_i
);
  import plbt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADD_SCAN, S_ADD_INS, S_SET_SCAN,
    S_EV_SCAN, S_EV_MUL, S_EV_DIV, S_EV_WAIT, S_FIN
  } state_e;

  state_e state_q, state_d;

  coord_t xs_q [MAX_POINTS];
  coord_t xs_d [MAX_POINTS];
  coord_t ys_q [MAX_POINTS];
  coord_t ys_d [MAX_POINTS];
  logic [CNT_W-1:0] count_q, count_d;

  coord_t x_min_q, x_max_q, y_min_q, y_max_q;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  idx_n;
  coord_t            x_q, x_d, y_q, y_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic              found_q, found_d;
  logic              clash_q, clash_d;
  coord_t            px_q, px_d, py_q, py_d;
  logic              neg_q, neg_d;
  divw_t             mag_q, mag_d, dxv_q, dxv_d, den_q, den_d;
  logic [2*DIV_W-1:0] prod_q, prod_d;
  coord_t            val_q, val_d;
  logic [STATUS_W-1:0] st_q, st_d;

  logic              ov_q, ov_d;
  coord_t            ov_val_q, ov_val_d;
  logic [STATUS_W-1:0] ov_st_q, ov_st_d;
  logic [CNT_W-1:0]  ov_cnt_q, ov_cnt_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  coord_t             rd_x, rd_y, lo, hi;
  logic [CNT_W-1:0]   last;
  logic               at_last;
  logic signed [COORD_WIDTH:0] tsum, dy, dx, dd, res;
  logic [IDX_W-1:0]   ins_pos;

  plbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.value = ov_val_q;
  assign out_o.status = ov_st_q;
  assign out_o.point_count = ov_cnt_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= RST_X_MIN;
      x_max_q <= RST_X_MAX;
      y_min_q <= RST_Y_MIN;
      y_max_q <= RST_Y_MAX;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_X_MIN: x_min_q <= cfg_i.data;
        REG_X_MAX: x_max_q <= cfg_i.data;
        REG_Y_MIN: y_min_q <= cfg_i.data;
        REG_Y_MAX: y_max_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    xs_d    = xs_q;
    ys_d    = ys_q;
    count_d = count_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    x_d     = x_q;
    y_d     = y_q;
    k_d     = k_q;
    pos_d   = pos_q;
    found_d = found_q;
    clash_d = clash_q;
    px_d    = px_q;
    py_d    = py_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    dxv_d   = dxv_q;
    den_d   = den_q;
    prod_d  = prod_q;
    val_d   = val_q;
    st_d    = st_q;
    ov_d    = ov_q;
    ov_val_d = ov_val_q;
    ov_st_d  = ov_st_q;
    ov_cnt_d = ov_cnt_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = den_q;

    rd_x    = xs_q[k_q];
    rd_y    = ys_q[k_q];
    last    = count_q - CNT_W'(1);
    at_last = (CNT_W'(k_q) == last);
    idx_n   = CNT_W'(idx_q);
    tsum    = {y_min_q[COORD_WIDTH-1], y_min_q} + {y_max_q[COORD_WIDTH-1], y_max_q};
    lo      = (x_min_q < x_max_q) ? x_min_q : x_max_q;
    hi      = (x_min_q < x_max_q) ? x_max_q : x_min_q;
    dy      = {rd_y[COORD_WIDTH-1], rd_y} - {py_q[COORD_WIDTH-1], py_q};
    dx      = {x_q[COORD_WIDTH-1], x_q} - {px_q[COORD_WIDTH-1], px_q};
    dd      = {rd_x[COORD_WIDTH-1], rd_x} - {px_q[COORD_WIDTH-1], px_q};
    res     = neg_q ? ({py_q[COORD_WIDTH-1], py_q} - $signed(div_rsp.quotient))
                    : ({py_q[COORD_WIDTH-1], py_q} + $signed(div_rsp.quotient));
    ins_pos = found_q ? pos_q : count_q[IDX_W-1:0];

    // Drop the result once taken
    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          idx_d   = IDX_W'(in_i.point_index);
          x_d     = in_i.x_coord;
          y_d     = in_i.y_coord;
          val_d   = '0;
          st_d    = ST_OK;
          k_d     = '0;
          found_d = 1'b0;
          clash_d = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        unique case (cmd_q)
          CMD_INIT: begin
            xs_d[0] = lo;
            ys_d[0] = tsum[COORD_WIDTH:1];
            xs_d[1] = hi;
            ys_d[1] = tsum[COORD_WIDTH:1];
            count_d = (lo == hi) ? CNT_W'(1) : CNT_W'(2);
          end
          CMD_ADD: state_d = S_ADD_SCAN;
          CMD_REMOVE: begin
            if (count_q <= CNT_W'(2)) begin
              st_d = ST_FEW;
            end else if (idx_n >= count_q) begin
              st_d = ST_BAD_IDX;
            end else begin
              // Shift the upper entries down over the removed one
              for (int j = 0; j < MAX_POINTS - 1; j++) begin
                if (IDX_W'(j) >= idx_q) begin
                  xs_d[j] = xs_q[j+1];
                  ys_d[j] = ys_q[j+1];
                end
              end
              count_d = count_q - CNT_W'(1);
            end
          end
          CMD_SET: begin
            if (idx_n >= count_q) st_d = ST_BAD_IDX;
            else state_d = S_SET_SCAN;
          end
          CMD_EVAL: state_d = S_EV_SCAN;
          default: ;
        endcase
      end
      S_ADD_SCAN: begin
        if (rd_x == x_q) clash_d = 1'b1;
        if (rd_x > x_q && !found_q) begin
          found_d = 1'b1;
          pos_d   = k_q;
        end
        if (at_last) state_d = S_ADD_INS;
        else k_d = k_q + IDX_W'(1);
      end
      S_ADD_INS: begin
        state_d = S_FIN;
        if (clash_q) begin
          st_d = ST_DUP_X;
        end else if (count_q >= CNT_W'(MAX_POINTS)) begin
          st_d = ST_FULL;
        end else begin
          // Open a gap at the insert position
          for (int j = 1; j < MAX_POINTS; j++) begin
            if (IDX_W'(j) > ins_pos) begin
              xs_d[j] = xs_q[j-1];
              ys_d[j] = ys_q[j-1];
            end
          end
          xs_d[ins_pos] = x_q;
          ys_d[ins_pos] = y_q;
          count_d = count_q + CNT_W'(1);
        end
      end
      S_SET_SCAN: begin
        if (rd_x == x_q && k_q != idx_q) clash_d = 1'b1;
        if (at_last) begin
          if (clash_d) begin
            ys_d[idx_q] = y_q;
            st_d    = ST_DUP_X;
            state_d = S_FIN;
          end else begin
            // Delete the point, then insert it anew
            for (int j = 0; j < MAX_POINTS - 1; j++) begin
              if (IDX_W'(j) >= idx_q) begin
                xs_d[j] = xs_q[j+1];
                ys_d[j] = ys_q[j+1];
              end
            end
            count_d = count_q - CNT_W'(1);
            k_d     = '0;
            found_d = 1'b0;
            clash_d = 1'b0;
            state_d = (count_q == CNT_W'(1)) ? S_ADD_INS : S_ADD_SCAN;
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_EV_SCAN: begin
        if ((k_q == '0 && x_q <= rd_x) || (at_last && x_q >= rd_x)) begin
          val_d   = rd_y;
          state_d = S_FIN;
        end else if (k_q != '0 && rd_x >= x_q) begin
          neg_d   = dy[COORD_WIDTH];
          mag_d   = dy[COORD_WIDTH] ? DIV_W'(-dy) : DIV_W'(dy);
          dxv_d   = DIV_W'(dx);
          den_d   = DIV_W'(dd);
          state_d = S_EV_MUL;
        end else begin
          px_d = rd_x;
          py_d = rd_y;
          k_d  = k_q + IDX_W'(1);
        end
      end
      S_EV_MUL: begin
        prod_d  = mag_q * dxv_q;
        state_d = S_EV_DIV;
      end
      S_EV_DIV: begin
        div_req.start = 1'b1;
        state_d = S_EV_WAIT;
      end
      S_EV_WAIT: begin
        if (div_rsp.done) begin
          val_d   = res[COORD_WIDTH-1:0];
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!ov_q || out_o.ready) begin
          ov_d     = 1'b1;
          ov_val_d = val_q;
          ov_st_d  = st_q;
          ov_cnt_d = count_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, table and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CNT_W'(2);
      ov_q    <= 1'b0;
      for (int j = 0; j < MAX_POINTS; j++) begin
        xs_q[j] <= '0;
        ys_q[j] <= '0;
      end
      xs_q[0] <= RST_X_MIN;
      xs_q[1] <= RST_X_MAX;
      ys_q[0] <= RST_MID;
      ys_q[1] <= RST_MID;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      xs_q    <= xs_d;
      ys_q    <= ys_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    x_q      <= x_d;
    y_q      <= y_d;
    k_q      <= k_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    clash_q  <= clash_d;
    px_q     <= px_d;
    py_q     <= py_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    dxv_q    <= dxv_d;
    den_q    <= den_d;
    prod_q   <= prod_d;
    val_q    <= val_d;
    st_q     <= st_d;
    ov_val_q <= ov_val_d;
    ov_st_q  <= ov_st_d;
    ov_cnt_q <= ov_cnt_d;
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_piecewise_linear_breakpoint_table.sv -----
// Testbench for the piecewise linear breakpoint table: a scoreboard class
// predicts every result item and checks them in order. Depends on plbt_pkg,
// the channel interfaces and the top level.
`timescale 1ns / 100ps
module tb_piecewise_linear_breakpoint_table;
  import plbt_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    coord_t                value;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      point_count;
  } plbt_result_t;

  // Table predictor and queue of pending results
  class plbt_table_sb;
    int xs[MAX_POINTS];
    int ys[MAX_POINTS];
    int cnt;
    int reg_v[4];
    plbt_result_t pending[$];
    int mismatches;
    int n_checked;
    int n_evals;
    int n_status[5];

    function new();
      reg_v[REG_X_MIN] = -16384;
      reg_v[REG_X_MAX] = 16384;
      reg_v[REG_Y_MIN] = 0;
      reg_v[REG_Y_MAX] = 255;
      reload();
    endfunction

    // Load the two end points from the registers
    function void reload();
      int mid;
      int lo;
      int hi;
      mid = (reg_v[REG_Y_MIN] + reg_v[REG_Y_MAX]) >>> 1;
      lo = (reg_v[REG_X_MIN] < reg_v[REG_X_MAX]) ? reg_v[REG_X_MIN] : reg_v[REG_X_MAX];
      hi = (reg_v[REG_X_MIN] < reg_v[REG_X_MAX]) ? reg_v[REG_X_MAX] : reg_v[REG_X_MIN];
      xs[0] = lo;
      ys[0] = mid;
      xs[1] = hi;
      ys[1] = mid;
      cnt = (lo == hi) ? 1 : 2;
    endfunction

    function bit x_taken(int x, int skip);
      for (int i = 0; i < cnt; i++)
        if (i != skip && xs[i] == x) return 1;
      return 0;
    endfunction

    function void insert_point(int x, int y);
      int p;
      p = 0;
      while (p < cnt && xs[p] < x) p++;
      for (int i = cnt; i > p; i--) begin
        xs[i] = xs[i-1];
        ys[i] = ys[i-1];
      end
      xs[p] = x;
      ys[p] = y;
      cnt++;
    endfunction

    function void drop_point(int idx);
      for (int i = idx; i + 1 < cnt; i++) begin
        xs[i] = xs[i+1];
        ys[i] = ys[i+1];
      end
      cnt--;
    endfunction

    // Clamp at the ends, else interpolate with truncation toward zero
    function int interpolate(int x);
      int i;
      longint dy;
      longint q;
      if (x <= xs[0]) return ys[0];
      if (x >= xs[cnt-1]) return ys[cnt-1];
      i = 1;
      while (i < cnt - 1 && xs[i] < x) i++;
      dy = ys[i] - ys[i-1];
      q = ((dy < 0 ? -dy : dy) * longint'(x - xs[i-1])) / longint'(xs[i] - xs[i-1]);
      return (dy < 0) ? ys[i-1] - int'(q) : ys[i-1] + int'(q);
    endfunction

    function void note_cfg(logic [CFG_IDX_W-1:0] idx, coord_t data);
      reg_v[idx] = int'(data);
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [PIDX_W-1:0] idx,
                            coord_t xc, coord_t yc);
      plbt_result_t r;
      int x;
      int y;
      x = int'(xc);
      y = int'(yc);
      r.value = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INIT: reload();
        CMD_ADD: begin
          if (x_taken(x, -1)) r.status = ST_DUP_X;
          else if (cnt >= MAX_POINTS) r.status = ST_FULL;
          else insert_point(x, y);
        end
        CMD_REMOVE: begin
          if (cnt <= 2) r.status = ST_FEW;
          else if (idx >= cnt) r.status = ST_BAD_IDX;
          else drop_point(idx);
        end
        CMD_SET: begin
          if (idx >= cnt) r.status = ST_BAD_IDX;
          else if (x_taken(x, idx)) begin
            ys[idx] = y;
            r.status = ST_DUP_X;
          end else begin
            drop_point(idx);
            insert_point(x, y);
          end
        end
        CMD_EVAL: begin
          r.value = coord_t'(interpolate(x));
          n_evals++;
        end
        default: ;
      endcase
      r.point_count = CNT_W'(cnt);
      n_status[r.status]++;
      pending = {pending, r};
    endfunction

    function void check(coord_t value, logic [STATUS_W-1:0] status,
                        logic [CNT_W-1:0] point_count);
      plbt_result_t e;
      n_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: value %0d status %0d count %0d",
                   value, status, point_count);
        return;
      end
      e = pending.pop_front();
      if (value !== e.value || status !== e.status || point_count !== e.point_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected value %0d status %0d count %0d, got %0d %0d %0d",
                   n_checked, e.value, e.status, e.point_count, value, status, point_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  plbt_in_if  in_if();
  plbt_out_if out_if();
  plbt_cfg_if cfg_if();
  plbt_table_sb sb;

  bit quiet;
  bit hold_req;
  int n_items;
  int stall_cycles;

  piecewise_linear_breakpoint_table i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .out_o(out_if), .cfg_i(cfg_if)
  );

  always #5 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = '0;
    in_if.point_index = '0;
    in_if.x_coord = '0;
    in_if.y_coord = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Check result items as they leave
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check(out_if.value, out_if.status, out_if.point_count);
  end

  // Stall the result side in bursts, or for one long hold
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one command item and hold it until accepted
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [PIDX_W-1:0] idx,
                           coord_t xc, coord_t yc);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.point_index <= idx;
    in_if.x_coord <= xc;
    in_if.y_coord <= yc;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(cmd, idx, xc, yc);
    n_items++;
  endtask

  // Let every pending result drain, then settle the block
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.note_cfg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(int xa, int xb, int ya, int yb);
    wait_idle();
    write_reg(REG_X_MIN, coord_t'(xa));
    write_reg(REG_X_MAX, coord_t'(xb));
    write_reg(REG_Y_MIN, coord_t'(ya));
    write_reg(REG_Y_MAX, coord_t'(yb));
    send_item(CMD_INIT, 4'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Pick an x: often one already in the table, sometimes an extreme
  function automatic coord_t pick_x();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return coord_t'(sb.xs[$urandom_range(0, sb.cnt - 1)]);
    if (r == 3) return coord_t'(sb.xs[$urandom_range(0, sb.cnt - 1)] + $urandom_range(0, 2) - 1);
    if (r == 4) return $urandom_range(0, 1) ? coord_t'(-32768) : coord_t'(32767);
    return coord_t'($urandom);
  endfunction

  task automatic send_random();
    int r;
    logic [CMD_W-1:0] cmd;
    logic [PIDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 2) cmd = CMD_INIT;
    else if (r < 32) cmd = CMD_ADD;
    else if (r < 47) cmd = CMD_REMOVE;
    else if (r < 64) cmd = CMD_SET;
    else if (r < 97) cmd = CMD_EVAL;
    else cmd = CMD_W'($urandom_range(5, 7));
    idx = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, sb.cnt - 1));
    send_item(cmd, idx, pick_x(), coord_t'($urandom));
  endtask

  task automatic run_phase(int n);
    repeat (n) send_random();
  endtask

  initial begin
    @(posedge rst_n);
    @(posedge clk);

    // Directed: clamping, interpolation, every status but full, unused codes
    send_item(CMD_EVAL, 0, coord_t'(-32768), 0);
    send_item(CMD_EVAL, 0, coord_t'(32767), 0);
    send_item(CMD_ADD, 0, coord_t'(0), coord_t'(-32768));
    send_item(CMD_EVAL, 0, coord_t'(-8191), 0);
    send_item(CMD_ADD, 0, coord_t'(100), coord_t'(32767));
    send_item(CMD_EVAL, 0, coord_t'(53), 0);
    send_item(CMD_ADD, 0, coord_t'(0), coord_t'(9));
    send_item(CMD_REMOVE, 15, 0, 0);
    send_item(CMD_SET, 15, 0, 0);
    send_item(CMD_SET, 1, coord_t'(100), coord_t'(-77));
    send_item(CMD_SET, 1, coord_t'(-32768), coord_t'(5));
    send_item(CMD_REMOVE, 0, 0, 0);
    for (logic [CMD_W-1:0] c = 5; c != 0; c++) send_item(c, 4'hf, coord_t'(-1), coord_t'(-1));
    for (int k = 0; k < 13; k++) send_item(CMD_ADD, 0, coord_t'(2000 * k + 7), coord_t'(k));
    send_item(CMD_INIT, 0, 0, 0);
    send_item(CMD_REMOVE, 0, 0, 0);

    // Random phases under several register settings
    run_phase(300);
    load_settings(-32768, 32767, -32768, 32767);
    hold_req = 1'b1;
    run_phase(300);
    load_settings(32767, -32768, 32767, 32767);
    run_phase(300);
    load_settings(5, 5, -32768, -32767);
    run_phase(300);
    load_settings($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
    run_phase(300);
    load_settings(-100, 100, -1, 0);
    quiet = 1'b1;
    run_phase(400);

    wait_idle();
    $display("%0d command items, %0d results, %0d evaluates; statuses ok/dup/full/few/bad %0d/%0d/%0d/%0d/%0d",
             n_items, sb.n_checked, sb.n_evals, sb.n_status[0], sb.n_status[1],
             sb.n_status[2], sb.n_status[3], sb.n_status[4]);
    $display("six register settings including reversed, equal and extreme end points");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
